/* sv/tccw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int ROW_W = 5;
  localparam int COL_W = 7;

  localparam logic [ROW_W:0] ROWS_X    = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0] COLUMNS_X = (COL_W + 1)'(COLUMNS);

  // Character codes.
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_CURSOR    = 8'h7C;

  // Configuration registers.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ATTR = 2'd1;

  localparam logic [7:0] TEXT_ATTR_RST   = 8'h0F;
  localparam logic [7:0] CURSOR_ATTR_RST = 8'h1B;

  // One item causes at most this many cell writes.
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = 2;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       glyph;
    logic [7:0]       attr;
    logic             clear_all;
    logic             last;
  } cell_t;

endpackage

`default_nettype wire

/* sv/text_console_cursor_writer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Text console cursor writer. Each character item turns into two to four text-cell
// writes, delivered one per cycle on the output channel while out_stall is low:
// the blank of the old cursor cell, the printed or erased cell if any, a clear-all
// write when the cursor runs off the bottom row, and the cursor glyph, which
// carries last. The single output port sets the rate. One input register holds
// the next item while the writes of the previous one drain, so a new item is
// taken as soon as that register empties. Attribute registers are written
// through the configuration port and are read at expansion time.
module text_console_cursor_writer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    char_code,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tccw_pkg::ROW_W-1:0]         row,
  output logic [tccw_pkg::COL_W-1:0]         col,
  output logic [7:0]                         glyph,
  output logic [7:0]                         attr,
  output logic                               clear_all,
  output logic                               last
);
  import tccw_pkg::*;

  logic [7:0]                  text_attr;
  logic [7:0]                  cursor_attr;
  logic [ROW_W-1:0]            cur_row;
  logic [COL_W-1:0]            cur_col;

  logic                        slot_vld;
  logic [7:0]                  slot_char;

  logic                        batch_vld;
  logic [RES_IDX_W-1:0]        idx;
  logic [RES_IDX_W-1:0]        cnt_m1;
  cell_t [MAX_RES-1:0]         batch;

  cell_t [MAX_RES-1:0]         exp_cells;
  logic [RES_IDX_W-1:0]        exp_cnt_m1;
  logic [ROW_W-1:0]            row_next;
  logic [COL_W-1:0]            col_next;

  logic                        out_take;
  logic                        batch_done;
  logic                        move;
  cell_t                       head;

  tccw_expand u_expand (
    .char_code   (slot_char),
    .cur_row     (cur_row),
    .cur_col     (cur_col),
    .text_attr   (text_attr),
    .cursor_attr (cursor_attr),
    .cells       (exp_cells),
    .cnt_m1      (exp_cnt_m1),
    .new_row     (row_next),
    .new_col     (col_next)
  );

  assign cfg_ready  = 1'b1;
  assign in_stall   = slot_vld;
  assign out_take   = batch_vld && !out_stall;
  assign batch_done = out_take && (idx == cnt_m1);
  // The held item expands into the batch once the previous batch is gone.
  assign move       = slot_vld && (!batch_vld || batch_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr   <= TEXT_ATTR_RST;
      cursor_attr <= CURSOR_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXT_ATTR:   text_attr   <= cfg_data;
        CFG_CURSOR_ATTR: cursor_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= 1'b0;
    end else if (in_valid && !in_stall) begin
      slot_vld <= 1'b1;
    end else if (move) begin
      slot_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      slot_char <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_vld <= 1'b0;
      idx       <= '0;
      cnt_m1    <= '0;
      cur_row   <= ROW_W'(1);
      cur_col   <= COL_W'(1);
    end else if (move) begin
      batch_vld <= 1'b1;
      idx       <= '0;
      cnt_m1    <= exp_cnt_m1;
      cur_row   <= row_next;
      cur_col   <= col_next;
    end else if (batch_done) begin
      batch_vld <= 1'b0;
      idx       <= '0;
    end else if (out_take) begin
      idx <= idx + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      batch <= exp_cells;
    end
  end

  assign head      = batch[idx];
  assign out_valid = batch_vld;
  assign row       = head.row;
  assign col       = head.col;
  assign glyph     = head.glyph;
  assign attr      = head.attr;
  assign clear_all = head.clear_all;
  assign last      = head.last;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    batch_vld |-> (idx <= cnt_m1))
    else $error("write index ran past the batch");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    batch_vld |-> (last == (idx == cnt_m1)))
    else $error("last flag does not mark the final write of the batch");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (cur_row != '0) && (cur_col != '0) && ({1'b0, cur_row} < ROWS_X)
      && ({1'b0, cur_col} < COLUMNS_X))
    else $error("cursor left the screen");

  a_batch_min_two: assert property (@(posedge clk) disable iff (rst)
    move |-> (exp_cnt_m1 != '0))
    else $error("item expanded to fewer than two writes");

endmodule

`default_nettype wire

/* sv/tccw_expand.sv */
`timescale 1ns / 1ps
`default_nettype none

module tccw_expand (
  input  wire logic [7:0]                       char_code,
  input  wire logic [tccw_pkg::ROW_W-1:0]       cur_row,
  input  wire logic [tccw_pkg::COL_W-1:0]       cur_col,
  input  wire logic [7:0]                       text_attr,
  input  wire logic [7:0]                       cursor_attr,
  output tccw_pkg::cell_t [tccw_pkg::MAX_RES-1:0] cells,
  output logic [tccw_pkg::RES_IDX_W-1:0]        cnt_m1,
  output logic [tccw_pkg::ROW_W-1:0]            new_row,
  output logic [tccw_pkg::COL_W-1:0]            new_col
);
  import tccw_pkg::*;

  logic [ROW_W-1:0]     row_inc;
  logic [COL_W-1:0]     col_inc;
  logic                 col_wrap;
  logic                 row_wrap;
  cell_t                blank0;
  cell_t                mid;
  cell_t                clr_cell;
  cell_t                cur_cell;
  logic                 mid_vld;
  logic                 do_nl;
  logic                 clr;
  logic [RES_IDX_W-1:0] n;

  assign row_inc  = cur_row + ROW_W'(1);
  assign col_inc  = cur_col + COL_W'(1);
  assign row_wrap = ({1'b0, row_inc} >= ROWS_X) || (row_inc == '0);
  assign col_wrap = ({1'b0, col_inc} >= COLUMNS_X) || (col_inc == '0);

  assign blank0   = '{row: cur_row, col: cur_col, glyph: CH_SPACE, attr: text_attr,
                      clear_all: 1'b0, last: 1'b0};
  assign clr_cell = '{row: '0, col: '0, glyph: CH_SPACE, attr: text_attr,
                      clear_all: 1'b1, last: 1'b0};

  always_comb begin
    mid     = blank0;
    mid_vld = 1'b0;
    do_nl   = 1'b0;
    new_row = cur_row;
    new_col = cur_col;
    if (char_code == CH_NEWLINE) begin
      do_nl = 1'b1;
    end else if (char_code == CH_BACKSPACE) begin
      if (cur_col > COL_W'(1)) begin
        mid_vld = 1'b1;
        mid.col = cur_col - COL_W'(1);
        new_col = cur_col - COL_W'(1);
      end
    end else begin
      mid_vld   = 1'b1;
      mid.glyph = char_code;
      if (col_wrap) begin
        do_nl = 1'b1;
      end else begin
        new_col = col_inc;
      end
    end

    clr = 1'b0;
    if (do_nl) begin
      new_col = COL_W'(1);
      if (row_wrap) begin
        clr     = 1'b1;
        new_row = ROW_W'(1);
      end else begin
        new_row = row_inc;
      end
    end
  end

  assign cur_cell = '{row: new_row, col: new_col, glyph: CH_CURSOR, attr: cursor_attr,
                      clear_all: 1'b0, last: 1'b1};

  // Pack the writes in order: blank, optional middle write, optional clear, cursor.
  always_comb begin
    cells    = {MAX_RES{cur_cell}};
    cells[0] = blank0;
    n        = RES_IDX_W'(1);
    if (mid_vld) begin
      cells[n] = mid;
      n        = n + RES_IDX_W'(1);
    end
    if (clr) begin
      cells[n] = clr_cell;
      n        = n + RES_IDX_W'(1);
    end
    cells[n] = cur_cell;
    cnt_m1   = n;
  end

endmodule

`default_nettype wire
